@@ rtl/assert_macros.svh @@
// Assertion macros shared by the limiter RTL.
// Expects a clock named clk and an active-high reset named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside of reset
`define ETSL_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("etsl assertion failed");

// Checked on every clock edge, reset included
`define ETSL_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("etsl assertion failed, reset included");

`endif

@@ rtl/etsl_pkg.sv @@
// Shared types and constants for the energy trip signal limiter.
// No dependencies; imported by every module of the block.
package etsl_pkg;

  localparam int DATA_W       = 32;
  localparam int Q_FRAC       = 16;
  localparam int ETSL_Q_DEPTH = 4;
  localparam int CFG_IDX_W    = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IMPEDANCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEAT_CAP  = 2'd2;

  // Request codes
  localparam logic REQ_INGEST = 1'b0;
  localparam logic REQ_HALT   = 1'b1;

  // Register reset values (Q16.16)
  localparam logic signed [DATA_W-1:0] IMPEDANCE_RST = 32'sd65536;
  localparam logic signed [DATA_W-1:0] THRESHOLD_RST = 32'sd0;
  localparam logic signed [DATA_W-1:0] HEAT_CAP_RST  = 32'sd262144;

  typedef struct packed {
    logic signed [DATA_W-1:0] impedance;
    logic signed [DATA_W-1:0] excess_threshold;
    logic signed [DATA_W-1:0] heat_cap;
  } cfg_t;

  // Classified item passed from front to back
  typedef struct packed {
    logic                     req_type;
    logic signed [DATA_W-1:0] raw_signal;
    logic signed [DATA_W-1:0] heat;
  } q_entry_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] filtered_signal;
    logic                     accepted;
    logic                     attenuated;
    logic                     halted;
    logic [DATA_W-1:0]        sample_count;
    logic [DATA_W-1:0]        overload_count;
  } result_t;

endpackage

@@ rtl/energy_trip_signal_limiter.sv @@
// Energy trip signal limiter, top level.
// Depends on etsl_pkg, etsl_front, etsl_queue, etsl_back and assert_macros.svh.
//
// Usage:
//   Input stream s_*: one transfer per sample or force-halt request.
//   s_tuser carries req_type (0 ingest, 1 force halt); s_tdata carries the
//   Q16.16 raw_signal and weight. Output stream m_*: exactly one result per
//   input transfer, in order. Configuration registers (impedance, excess
//   threshold, heat cap) are written through cfg_wr_en/cfg_index/cfg_wdata;
//   the user must write them only while the block is idle (not enforced).
//   Path of an item: the power product is registered at the transfer, the
//   weighted heat at the queue write, and the decision in the output
//   register; items waiting in the queue or a low m_tready hold it back.
//   Throughput: one item per cycle sustained while m_tready is high; the
//   only loop between items is the back end's accumulate-and-compare step.
//   A four-entry queue separates front and back; s_tready drops when the
//   queue plus the item in the multiply stage would fill it.
//   When m_tready is low the result holds in the output register, the back
//   end stops popping, and the front keeps filling the queue until full.
//   Reset clears the halt state, accumulator, counters and the queue, and
//   loads the register defaults. Only reset leaves the halt state.
module energy_trip_signal_limiter #(
  parameter int Q_DEPTH = etsl_pkg::ETSL_Q_DEPTH
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [63:0]                        s_tdata,   // raw_signal, weight
  input  logic                               s_tuser,   // req_type
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // filtered_signal, halted, sample_count, overload_count, zero pad
  output logic [103:0]                       m_tdata,
  output logic [1:0]                         m_tuser,   // accepted, attenuated
  input  logic                               cfg_wr_en,
  input  logic [etsl_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [etsl_pkg::DATA_W-1:0]        cfg_wdata
);
  import etsl_pkg::*;

  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  cfg_t              cfg;
  logic              push;
  q_entry_t          push_entry;
  logic              pop;
  logic              head_valid;
  q_entry_t          head_entry;
  logic [CNT_W-1:0]  q_count;
  result_t           out_result;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.impedance        <= IMPEDANCE_RST;
      cfg.excess_threshold <= THRESHOLD_RST;
      cfg.heat_cap         <= HEAT_CAP_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_IMPEDANCE: cfg.impedance        <= cfg_wdata;
        CFG_THRESHOLD: cfg.excess_threshold <= cfg_wdata;
        CFG_HEAT_CAP:  cfg.heat_cap         <= cfg_wdata;
        default: ;
      endcase
    end
  end

  etsl_front #(
    .Q_DEPTH (Q_DEPTH),
    .CNT_W   (CNT_W)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (s_tvalid),
    .in_ready      (s_tready),
    .in_req_type   (s_tuser),
    .in_raw_signal (s_tdata[31:0]),
    .in_weight     (s_tdata[63:32]),
    .q_count       (q_count),
    .push          (push),
    .push_entry    (push_entry)
  );

  etsl_queue #(
    .Q_DEPTH (Q_DEPTH),
    .CNT_W   (CNT_W)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head_valid (head_valid),
    .head_entry (head_entry),
    .count      (q_count)
  );

  etsl_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head_valid (head_valid),
    .head_entry (head_entry),
    .pop        (pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_result (out_result)
  );

  // Output packing
  assign m_tdata = {7'd0,
                    out_result.overload_count,
                    out_result.sample_count,
                    out_result.halted,
                    out_result.filtered_signal};
  assign m_tuser = {out_result.attenuated, out_result.accepted};

`include "assert_macros.svh"

  // Queue never overfills
  `ETSL_ASSERT(a_queue_bound, q_count <= CNT_W'(Q_DEPTH))
  // Credit keeps a slot for the item in the multiply stage
  `ETSL_ASSERT(a_push_room, push |-> (q_count < CNT_W'(Q_DEPTH)) || pop)
  // Halt is sticky until reset
  `ETSL_ASSERT(a_halt_sticky, (m_tvalid && m_tdata[32]) |=> (!m_tvalid || m_tdata[32]))
  // A rejected result carries zero and is never marked attenuated
  `ETSL_ASSERT(a_reject_zero,
    (m_tvalid && !m_tuser[0]) |-> (m_tdata[31:0] == '0 && !m_tuser[1]))

endmodule

@@ rtl/etsl_front.sv @@
// Front end: accepts input transfers and computes heat in two multiply stages.
// Depends on etsl_pkg; pushes into etsl_queue under a slot-count credit.
module etsl_front #(
  parameter int Q_DEPTH = etsl_pkg::ETSL_Q_DEPTH,
  parameter int CNT_W   = $clog2(Q_DEPTH + 1)
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_req_type,
  input  logic signed [etsl_pkg::DATA_W-1:0] in_raw_signal,
  input  logic signed [etsl_pkg::DATA_W-1:0] in_weight,
  input  logic [CNT_W-1:0]                 q_count,
  output logic                             push,
  output etsl_pkg::q_entry_t               push_entry
);
  import etsl_pkg::*;

  logic                        s1_valid;
  logic                        s1_req;
  logic signed [DATA_W-1:0]    s1_sig;
  logic signed [DATA_W-1:0]    s1_weight;
  logic signed [DATA_W-1:0]    s1_power;
  logic signed [2*DATA_W-1:0]  power_full;
  logic signed [2*DATA_W-1:0]  heat_full;
  logic [CNT_W:0]              slots_used;
  logic                        in_fire;

  // Credit: items already queued plus the one in flight must leave a slot
  assign slots_used = {1'b0, q_count} + (CNT_W+1)'(s1_valid);
  assign in_ready   = slots_used < (CNT_W+1)'(Q_DEPTH);
  assign in_fire    = in_valid && in_ready;

  // Signal power, Q16.16 with wrap
  assign power_full = in_raw_signal * in_raw_signal;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_req    <= in_req_type;
      s1_sig    <= in_raw_signal;
      s1_weight <= in_weight;
      s1_power  <= power_full[Q_FRAC +: DATA_W];
    end
  end

  // Weighted heat, registered by the queue write
  assign heat_full = s1_power * s1_weight;

  assign push                  = s1_valid;
  assign push_entry.req_type   = s1_req;
  assign push_entry.raw_signal = s1_sig;
  assign push_entry.heat       = heat_full[Q_FRAC +: DATA_W];

endmodule

@@ rtl/etsl_queue.sv @@
// Small FIFO between the front end and the back end.
// Depends on etsl_pkg for the entry type; Q_DEPTH of 2 or more.
module etsl_queue #(
  parameter int Q_DEPTH = etsl_pkg::ETSL_Q_DEPTH,
  parameter int CNT_W   = $clog2(Q_DEPTH + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  etsl_pkg::q_entry_t  push_entry,
  input  logic                pop,
  output logic                head_valid,
  output etsl_pkg::q_entry_t  head_entry,
  output logic [CNT_W-1:0]    count
);
  import etsl_pkg::*;

  localparam int PTR_W = $clog2(Q_DEPTH);

  q_entry_t          entries [Q_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;

  assign head_valid = count != '0;
  assign head_entry = entries[rd_ptr];

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ rtl/etsl_back.sv @@
// Back end: accumulate, trip and halt decision, counters and output register.
// Depends on etsl_pkg; pops etsl_queue when the output register is free.
module etsl_back (
  input  logic                clk,
  input  logic                rst,
  input  etsl_pkg::cfg_t      cfg,
  input  logic                head_valid,
  input  etsl_pkg::q_entry_t  head_entry,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output etsl_pkg::result_t   out_result
);
  import etsl_pkg::*;

  logic signed [DATA_W-1:0] heat_acc;
  logic                     halt_flag;
  logic [DATA_W-1:0]        ingest_cnt;
  logic [DATA_W-1:0]        overload_cnt;

  logic signed [DATA_W-1:0] heat_acc_next;
  logic                     halt_flag_next;
  logic [DATA_W-1:0]        ingest_cnt_next;
  logic [DATA_W-1:0]        overload_cnt_next;
  logic signed [DATA_W-1:0] excess;
  logic signed [DATA_W-1:0] acc_sum;
  result_t                  result_next;

  assign pop     = head_valid && (!out_valid || out_ready);
  assign excess  = head_entry.heat - cfg.impedance;
  assign acc_sum = heat_acc + head_entry.heat;

  // Per-item decision
  always_comb begin
    heat_acc_next     = heat_acc;
    halt_flag_next    = halt_flag;
    ingest_cnt_next   = ingest_cnt;
    overload_cnt_next = overload_cnt;
    result_next       = '0;
    if (head_entry.req_type == REQ_HALT) begin
      halt_flag_next = 1'b1;
      heat_acc_next  = '0;
    end else if (!halt_flag) begin
      ingest_cnt_next = ingest_cnt + 1'b1;
      if (excess > cfg.excess_threshold) begin
        overload_cnt_next = overload_cnt + 1'b1;
        if (acc_sum >= cfg.heat_cap) begin
          // trip into sticky halt
          halt_flag_next = 1'b1;
          heat_acc_next  = '0;
        end else begin
          heat_acc_next              = acc_sum;
          result_next.filtered_signal = head_entry.raw_signal >>> 1;
          result_next.accepted        = 1'b1;
          result_next.attenuated      = 1'b1;
        end
      end else begin
        heat_acc_next               = '0;
        result_next.filtered_signal = head_entry.raw_signal;
        result_next.accepted        = 1'b1;
      end
    end
    result_next.halted         = halt_flag_next;
    result_next.sample_count   = ingest_cnt_next;
    result_next.overload_count = overload_cnt_next;
  end

  // State and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      heat_acc     <= '0;
      halt_flag    <= 1'b0;
      ingest_cnt   <= '0;
      overload_cnt <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (pop) begin
        heat_acc     <= heat_acc_next;
        halt_flag    <= halt_flag_next;
        ingest_cnt   <= ingest_cnt_next;
        overload_cnt <= overload_cnt_next;
        out_valid    <= 1'b1;
      end else if (out_ready) begin
        out_valid    <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_result <= result_next;
    end
  end

endmodule
